// ===== rtl/b2bcd_pkg.sv =====
// ----------------------------------------------------------------------------
// b2bcd_pkg
// Shared request types and double dabble constants for the 128-bit
// binary to BCD converter.
// ----------------------------------------------------------------------------
`default_nettype none

package b2bcd_pkg;

  // Width of one BCD digit.
  localparam int unsigned DigitW = 4;

  // A digit at or above this limit is corrected before the next shift.
  localparam logic [DigitW-1:0] DabbleLimit = 4'd5;
  localparam logic [DigitW-1:0] DabbleAdd   = 4'd3;

  // Shift-and-correct steps done in one pipeline stage.
  localparam int unsigned StepsPerStage = 8;

  typedef struct packed {
    logic [63:0] value_high;
    logic [63:0] value_low;
  } in_req_t;

  typedef struct packed {
    logic [3:0] digit;
    logic       last_digit;
  } out_req_t;

endpackage : b2bcd_pkg

`default_nettype wire

// ===== rtl/b2bcd_stage.sv =====
// ----------------------------------------------------------------------------
// b2bcd_stage
// One pipeline stage of the converter: a fixed number of shift-and-add-3
// steps on the digit register, then a stage register with a valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module b2bcd_stage
  import b2bcd_pkg::*;
#(
  parameter int unsigned ValW       = 128,
  parameter int unsigned DigitCount = 39
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  input  wire logic [ValW-1:0]              value_i,
  input  wire logic [DigitCount*DigitW-1:0] digits_i,
  output logic                              valid_o,
  input  wire logic                         ready_i,
  output logic [ValW-1:0]                   value_o,
  output logic [DigitCount*DigitW-1:0]      digits_o
);

  localparam int unsigned BcdW = DigitCount * DigitW;

  logic            valid_q;
  logic [ValW-1:0] value_d, value_q;
  logic [BcdW-1:0] digits_d, digits_q;

  // Each step corrects every digit, then shifts the next value bit in at
  // the least significant digit. The carry out of the top digit is dropped.
  always_comb begin
    logic [BcdW-1:0] bcd;
    logic [ValW-1:0] val;
    bcd = digits_i;
    val = value_i;
    for (int s = 0; s < StepsPerStage; s++) begin
      for (int j = 0; j < DigitCount; j++) begin
        if (bcd[j*DigitW +: DigitW] >= DabbleLimit) begin
          bcd[j*DigitW +: DigitW] = bcd[j*DigitW +: DigitW] + DabbleAdd;
        end
      end
      bcd = {bcd[BcdW-2:0], val[ValW-1]};
      val = {val[ValW-2:0], 1'b0};
    end
    digits_d = bcd;
    value_d  = val;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      value_q  <= value_d;
      digits_q <= digits_d;
    end
  end

  assign valid_o  = valid_q;
  assign value_o  = value_q;
  assign digits_o = digits_q;

endmodule : b2bcd_stage

`default_nettype wire

// ===== rtl/b2bcd_emit.sv =====
// ----------------------------------------------------------------------------
// b2bcd_emit
// Digit serializer: takes a finished digit register, walks it from the most
// significant digit down, skips leading zeros and feeds an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b2bcd_emit
  import b2bcd_pkg::*;
#(
  parameter int unsigned DigitCount = 39
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  input  wire logic [DigitCount*DigitW-1:0] digits_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output out_req_t                          out_req_o
);

  localparam int unsigned BcdW = DigitCount * DigitW;
  localparam int unsigned CntW = $clog2(DigitCount);

  logic              busy_q;
  logic              started_q;
  logic [CntW-1:0]   cnt_q;
  logic [BcdW-1:0]   digits_q;
  logic              out_valid_q;
  out_req_t          out_req_q;

  logic [DigitW-1:0] head;
  logic              last_pos;
  logic              out_free;
  logic              emit;
  logic              advance;

  assign head     = digits_q[BcdW-1 -: DigitW];
  assign last_pos = (cnt_q == CntW'(DigitCount - 1));
  assign out_free = !out_valid_q || !out_stall_i;

  // The least significant digit is always sent, so a zero value gives one 0.
  assign emit    = busy_q && (started_q || (head != '0) || last_pos);
  // Leading zeros are dropped without waiting for the output register.
  assign advance = busy_q && (!emit || out_free);

  assign ready_o = !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      started_q   <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (!busy_q && valid_i) begin
        busy_q    <= 1'b1;
        started_q <= 1'b0;
        cnt_q     <= '0;
      end else if (advance) begin
        if (emit) begin
          started_q <= 1'b1;
        end
        if (last_pos) begin
          busy_q <= 1'b0;
          cnt_q  <= '0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && valid_i) begin
      digits_q <= digits_i;
    end else if (advance) begin
      digits_q <= {digits_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
    end
    if (out_free && emit) begin
      out_req_q.digit      <= head;
      out_req_q.last_digit <= last_pos;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule : b2bcd_emit

`default_nettype wire

// ===== rtl/binary_to_bcd_128.sv =====
// ----------------------------------------------------------------------------
// binary_to_bcd_128
// Unsigned binary to decimal digit stream, double dabble pipeline.
// ----------------------------------------------------------------------------
// A request carries an unsigned value as two 64-bit halves; only the low
// VALUE_BITS bits are converted. The value passes a pipeline of
// ceil(VALUE_BITS/8) stages (16 at the default), each doing eight
// shift-and-add-3 steps, so a new request can enter every cycle while the
// pipeline has room. Results leave one decimal digit per output request,
// most significant first, leading zeros dropped, with last_digit set on
// the least significant digit; a zero value gives a single 0. The digit
// serializer walks all DIGIT_COUNT digit positions one per cycle while the
// output does not stall, and takes no new request until it has walked them
// all; that serializer sets the sustained rate. A request passes the stage
// registers, then the serializer's digit register, then the output register;
// skipped leading zeros do not wait for the output register. A value too
// large for DIGIT_COUNT digits shows modulo 10^DIGIT_COUNT.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_bcd_128
  import b2bcd_pkg::*;
#(
  parameter int unsigned VALUE_BITS  = 128,
  parameter int unsigned DIGIT_COUNT = 39
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_req_t  in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_req_t      out_req_o
);

  localparam int unsigned StageCount = (VALUE_BITS + StepsPerStage - 1) / StepsPerStage;
  localparam int unsigned PadW       = StageCount * StepsPerStage;
  localparam int unsigned BcdW       = DIGIT_COUNT * DigitW;

  logic [127:0]    full_value;
  logic [PadW-1:0] pad_value;

  logic            stg_valid [StageCount+1];
  logic            stg_ready [StageCount+1];
  logic [PadW-1:0] stg_value [StageCount+1];
  logic [BcdW-1:0] stg_digits[StageCount+1];

  // Zero bits shifted in ahead of the value leave the digits at zero.
  assign full_value = {in_req_i.value_high, in_req_i.value_low};
  assign pad_value  = PadW'(full_value[VALUE_BITS-1:0]);

  assign stg_valid[0]  = in_valid_i;
  assign stg_value[0]  = pad_value;
  assign stg_digits[0] = '0;
  assign in_stall_o    = !stg_ready[0];

  for (genvar g = 0; g < StageCount; g++) begin : g_stage
    b2bcd_stage #(
      .ValW       (PadW),
      .DigitCount (DIGIT_COUNT)
    ) u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (stg_valid[g]),
      .ready_o  (stg_ready[g]),
      .value_i  (stg_value[g]),
      .digits_i (stg_digits[g]),
      .valid_o  (stg_valid[g+1]),
      .ready_i  (stg_ready[g+1]),
      .value_o  (stg_value[g+1]),
      .digits_o (stg_digits[g+1])
    );
  end

  b2bcd_emit #(
    .DigitCount (DIGIT_COUNT)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stg_valid[StageCount]),
    .ready_o     (stg_ready[StageCount]),
    .digits_i    (stg_digits[StageCount]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  // The input only stalls while the first stage holds a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stg_valid[1] |-> !in_stall_o)
    else $error("input stalled with an empty first stage");

  // Digits that leave the block are always decimal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.digit <= 4'd9))
    else $error("non-decimal digit on the output");

  // The serializer takes a new digit register only when it is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_valid[StageCount] && stg_ready[StageCount]) |=> !stg_ready[StageCount])
    else $error("serializer still ready after taking a request");

endmodule : binary_to_bcd_128

`default_nettype wire
